// File: rtl/wpm_pkg.sv
// Package with the request codes, character constants and matching helpers of the matcher.
`timescale 1ns / 1ps
`default_nettype none

package wpm_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_RESTART = 2'd2,
    REQ_TEXT    = 2'd3
  } req_e;

  localparam logic [7:0] CHAR_STAR     = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_QUESTION = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_HASH     = 8'h23;  // '#'
  localparam logic [7:0] CHAR_AT       = 8'h40;  // '@'
  localparam logic [7:0] CHAR_PERCENT  = 8'h25;  // '%'

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic       wr;         // store char_code into the selected cell
    logic       upd;        // load the new row bit
    logic       restart;    // the new row is the empty-text row
    logic [7:0] char_code;  // pattern byte or text byte
  } cell_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
  endfunction

  // True when a non-star pattern byte p accepts text byte t.
  function automatic logic byte_matches(input logic [7:0] p, input logic [7:0] t);
    byte_matches = (p == CHAR_QUESTION)
                || ((p == CHAR_HASH) && is_digit(t))
                || ((p == CHAR_AT) && is_alpha(t))
                || ((p == CHAR_PERCENT) && (is_alpha(t) || is_digit(t)))
                || (fold(p) == fold(t));
  endfunction

endpackage

`default_nettype wire

// File: rtl/wpm_if.sv
// Valid/ready channel interfaces for the request and the response words.
`timescale 1ns / 1ps
`default_nettype none

interface wpm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface wpm_rsp_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;
  logic text_overflow;

  modport source (output valid, output matched, output pattern_overflow,
                  output text_overflow, input ready);
  modport sink   (input valid, input matched, input pattern_overflow,
                  input text_overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/wildcard_pattern_matcher_core.sv
// Top level of the wildcard pattern matcher: request decode, cell row and response register.
`timescale 1ns / 1ps
`default_nettype none

// The matcher takes request words on req_i and returns one response word on
// rsp_o for every request. A request either clears the pattern, appends a
// pattern byte, restarts the text, or feeds one text byte. The response tells
// whether the text so far matches the whole pattern, plus two sticky overflow
// flags for a pattern longer than PATTERN_MAX and a text longer than TEXT_MAX.
//
// Each pattern position is a cell that holds its byte and its match bit. A
// text byte updates all cells at once; new bits ripple through runs of stars
// over one carry chain across the row, which sets the clock period.
//
// The response word of a request accepted at a clock edge is valid after that
// edge. Throughput is one request per cycle while rsp_o does not stall.
// The response sits in an output register; req_i.ready is low only while that
// register holds a word the receiver has not taken, so a stall on rsp_o backs
// up into req_i after one word and nothing is lost.
//
// Reset empties the pattern, clears both overflow flags and the text, and
// leaves no response pending. No clearing pass is needed after reset.

module wildcard_pattern_matcher_core #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned TEXT_MAX    = 128
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wpm_req_if.sink    req_i,
  wpm_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned TW = $clog2(TEXT_MAX + 1);

  logic [CW-1:0] pcount_q, pcount_d;
  logic [TW-1:0] tcount_q, tcount_d;
  logic          ptl_q, ptl_d;
  logic          ttl_q, ttl_d;
  logic          row0_q, row0_d;
  logic          accept;
  wpm_pkg::cell_ctl_t ctl;

  logic [PATTERN_MAX-1:0] gen, prop, carry, cell_row;
  logic [PATTERN_MAX:0]   row_all, row_nx;

  logic rsp_valid_q;
  logic matched_q, ptl_out_q, ttl_out_q;
  logic matched_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Request decode and the counters and flags that follow from it.
  always_comb begin
    pcount_d      = pcount_q;
    tcount_d      = tcount_q;
    ptl_d         = ptl_q;
    ttl_d         = ttl_q;
    ctl.wr        = 1'b0;
    ctl.upd       = 1'b0;
    ctl.restart   = 1'b0;
    ctl.char_code = req_i.char_code;
    if (accept) begin
      unique case (wpm_pkg::req_e'(req_i.req_type))
        wpm_pkg::REQ_CLEAR: begin
          pcount_d    = '0;
          ptl_d       = 1'b0;
          ctl.restart = 1'b1;
        end
        wpm_pkg::REQ_APPEND: begin
          if (pcount_q < CW'(PATTERN_MAX)) begin
            ctl.wr   = 1'b1;
            pcount_d = pcount_q + 1'b1;
          end else begin
            ptl_d = 1'b1;
          end
          ctl.restart = 1'b1;
        end
        wpm_pkg::REQ_RESTART: begin
          ctl.restart = 1'b1;
        end
        wpm_pkg::REQ_TEXT: begin
          if (tcount_q < TW'(TEXT_MAX)) begin
            ctl.upd  = 1'b1;
            tcount_d = tcount_q + 1'b1;
          end else begin
            ttl_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (ctl.restart) begin
        ctl.upd  = 1'b1;
        tcount_d = '0;
        ttl_d    = 1'b0;
      end
    end
  end

  // Row of cells; cell i holds pattern byte i and match bit i+1.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    wpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .sel_i      (pcount_q == CW'(i)),
      .active_i   (pcount_d > CW'(i)),
      .prev_row_i (row_all[i]),
      .carry_i    (carry[i]),
      .gen_o      (gen[i]),
      .prop_o     (prop[i]),
      .row_o      (cell_row[i])
    );
  end

  // The empty-text row starts with bit zero set; a text byte clears it.
  wpm_prefix #(.N(PATTERN_MAX)) u_prefix (
    .gen_i   (gen),
    .prop_i  (prop),
    .cin_i   (ctl.restart),
    .carry_o (carry)
  );

  assign row_all = {cell_row, row0_q};
  assign row0_d  = ctl.upd ? ctl.restart : row0_q;
  assign row_nx  = ctl.upd ? {carry, ctl.restart} : row_all;

  assign matched_d = !ptl_d && !ttl_d && row_nx[pcount_d];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q    <= '0;
      tcount_q    <= '0;
      ptl_q       <= 1'b0;
      ttl_q       <= 1'b0;
      row0_q      <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      pcount_q <= pcount_d;
      tcount_q <= tcount_d;
      ptl_q    <= ptl_d;
      ttl_q    <= ttl_d;
      row0_q   <= row0_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload loads only with a new word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      matched_q <= matched_d;
      ptl_out_q <= ptl_d;
      ttl_out_q <= ttl_d;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.matched          = matched_q;
  assign rsp_o.pattern_overflow = ptl_out_q;
  assign rsp_o.text_overflow    = ttl_out_q;

endmodule

`default_nettype wire

// File: rtl/wpm_cell.sv
// One pattern position: its stored byte, its match bit and its carry-chain terms.
`timescale 1ns / 1ps
`default_nettype none

module wpm_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wpm_pkg::cell_ctl_t ctl_i,
  input  wire logic              sel_i,
  input  wire logic              active_i,
  input  wire logic              prev_row_i,
  input  wire logic              carry_i,
  output logic                   gen_o,
  output logic                   prop_o,
  output logic                   row_o
);

  logic [7:0] pat_q, pat_d;
  logic       row_q;
  logic       is_star;

  always_comb begin
    pat_d   = (ctl_i.wr && sel_i) ? ctl_i.char_code : pat_q;
    is_star = (pat_d == wpm_pkg::CHAR_STAR);
    // A star carries the left neighbor's new bit on, or keeps its own bit.
    // Any other byte takes the left neighbor's old bit when the text byte fits.
    if (ctl_i.restart) begin
      gen_o  = 1'b0;
      prop_o = active_i && is_star;
    end else if (is_star) begin
      gen_o  = active_i && row_q;
      prop_o = active_i;
    end else begin
      gen_o  = active_i && prev_row_i && wpm_pkg::byte_matches(pat_d, ctl_i.char_code);
      prop_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q <= pat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else if (ctl_i.upd) begin
      row_q <= carry_i;
    end
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

// File: rtl/wpm_prefix.sv
// Carry chain that ripples new match bits through runs of stars across the cells.
`timescale 1ns / 1ps
`default_nettype none

module wpm_prefix #(
  parameter int unsigned N = 64
) (
  input  wire logic [N-1:0] gen_i,
  input  wire logic [N-1:0] prop_i,
  input  wire logic         cin_i,
  output logic      [N-1:0] carry_o
);

  logic [N-1:0] a, b;
  logic [N:0]   sum;
  logic [N:0]   xab_ext;

  // With a = g|p and b = g the adder carries c[k] = g[k] | p[k] & c[k-1].
  always_comb begin
    a       = gen_i | prop_i;
    b       = gen_i;
    sum     = {1'b0, a} + {1'b0, b} + {{N{1'b0}}, cin_i};
    xab_ext = {1'b0, a ^ b};
    carry_o = sum[N:1] ^ xab_ext[N:1];
  end

endmodule

`default_nettype wire

// File: rtl/wpm_checker.sv
// Port-level assertions for the wildcard pattern matcher and their bind.
`timescale 1ns / 1ps
`default_nettype none

module wpm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       req_valid_i,
  input wire logic       req_ready_i,
  input wire logic [1:0] req_type_i,
  input wire logic       rsp_valid_i,
  input wire logic       rsp_ready_i,
  input wire logic       matched_i,
  input wire logic       pattern_overflow_i,
  input wire logic       text_overflow_i
);

  // A match is never reported while an overflow flag is set.
  a_match_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(matched_i && (pattern_overflow_i || text_overflow_i)))
    else $error("match reported with an overflow flag set");

  // Clearing the pattern answers with a match of empty text on empty pattern.
  a_clear_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_type_i == wpm_pkg::REQ_CLEAR))
    |=> (rsp_valid_i && matched_i && !pattern_overflow_i && !text_overflow_i))
    else $error("clear did not answer with an empty match");

  // A held response blocks new requests.
  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |-> !req_ready_i)
    else $error("request taken while a response word is stalled");

  // A stalled response word holds.
  a_rsp_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> (rsp_valid_i && $stable(matched_i)
      && $stable(pattern_overflow_i) && $stable(text_overflow_i)))
    else $error("stalled response word changed");

endmodule

bind wildcard_pattern_matcher_core wpm_checker u_wpm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .req_type_i         (req_i.req_type),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .matched_i          (rsp_o.matched),
  .pattern_overflow_i (rsp_o.pattern_overflow),
  .text_overflow_i    (rsp_o.text_overflow)
);

`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for wildcard_pattern_matcher_core with predicted matches.
`timescale 1ns / 1ps

// The testbench feeds request words to the matcher and checks every response word
// against its own prediction of the match row. A queue of pending request words is
// filled by the stimulus process in phases. A clocked driver moves the words onto
// req_bus, and a clocked monitor takes response words from rsp_bus. Both sides idle
// at a rate that is set for each phase.
//
// The prediction is made when a request word is accepted. The expected response
// then waits in a queue until the monitor takes the matching response word.

module tb_top;

  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned TEXT_MAX    = 128;
  localparam int unsigned STALL_LIMIT = 2000;  // cycles without any handshake

  typedef struct {
    wpm_pkg::req_e kind;
    logic [7:0]    code;
  } req_word_t;

  typedef struct {
    logic matched;
    logic pat_ovf;
    logic txt_ovf;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  wpm_req_if req_bus ();
  wpm_rsp_if rsp_bus ();

  wildcard_pattern_matcher_core #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Request words waiting to be driven and responses waiting to arrive.
  req_word_t send_queue[$];
  verdict_t  verdicts_due[$];

  int unsigned words_queued;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  req_word_t   drv_word;

  // The predicted state of the matcher. The row holds one bit per pattern prefix:
  // bit j is set when the text so far matches the first j pattern bytes.
  logic [7:0]         pat_mem[PATTERN_MAX];
  int unsigned        pat_len;
  int unsigned        txt_len;
  logic               pat_ovf;
  logic               txt_ovf;
  logic [PATTERN_MAX:0] row_bits;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // True when a pattern byte other than a star accepts the text byte.
  function automatic logic char_accepts(input logic [7:0] p, input logic [7:0] t);
    logic digit;
    logic letter;
    logic p_letter;
    logic accept;
    digit    = (t >= "0") && (t <= "9");
    letter   = ((t | 8'h20) >= "a") && ((t | 8'h20) <= "z");
    p_letter = ((p | 8'h20) >= "a") && ((p | 8'h20) <= "z");
    // Case-blind compare first: fold both sides to lower case where they are letters.
    accept = ((p_letter ? (p | 8'h20) : p) == (letter ? (t | 8'h20) : t));
    case (p)
      wpm_pkg::CHAR_QUESTION: accept = 1'b1;
      wpm_pkg::CHAR_HASH:     accept = accept | digit;
      wpm_pkg::CHAR_AT:       accept = accept | letter;
      wpm_pkg::CHAR_PERCENT:  accept = accept | digit | letter;
      default: ;
    endcase
    return accept;
  endfunction

  // Empty text: only the prefixes made of stars alone match.
  function automatic void rewind_text();
    txt_len     = 0;
    txt_ovf     = 1'b0;
    row_bits    = '0;
    row_bits[0] = 1'b1;
    for (int j = 1; j <= pat_len; j++) begin
      row_bits[j] = (pat_mem[j-1] == wpm_pkg::CHAR_STAR) && row_bits[j-1];
    end
  endfunction

  function automatic void predict_request(input wpm_pkg::req_e kind, input logic [7:0] code);
    logic [PATTERN_MAX:0] next_row;
    verdict_t             v;
    case (kind)
      wpm_pkg::REQ_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        rewind_text();
      end
      wpm_pkg::REQ_APPEND: begin
        // A full pattern drops the byte but still restarts the text.
        if (pat_len < PATTERN_MAX) begin
          pat_mem[pat_len] = code;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
        rewind_text();
      end
      wpm_pkg::REQ_RESTART: rewind_text();
      default: begin
        // A text byte past the limit is dropped and leaves the row as it was.
        if (txt_len < TEXT_MAX) begin
          next_row = '0;
          for (int j = 1; j <= pat_len; j++) begin
            if (pat_mem[j-1] == wpm_pkg::CHAR_STAR) begin
              next_row[j] = next_row[j-1] || row_bits[j];
            end else if (char_accepts(pat_mem[j-1], code)) begin
              next_row[j] = row_bits[j-1];
            end
          end
          row_bits = next_row;
          txt_len++;
        end else begin
          txt_ovf = 1'b1;
        end
      end
    endcase
    v.matched = !pat_ovf && !txt_ovf && row_bits[pat_len];
    v.pat_ovf = pat_ovf;
    v.txt_ovf = txt_ovf;
    verdicts_due.push_back(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: holds a word until it is taken, then idles or sends the next one.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= wpm_pkg::REQ_CLEAR;
      req_bus.char_code <= 8'h00;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        predict_request(wpm_pkg::req_e'(req_bus.req_type), req_bus.char_code);
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_word           = send_queue.pop_front();
          req_bus.valid     <= 1'b1;
          req_bus.req_type  <= drv_word.kind;
          req_bus.char_code <= drv_word.code;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each response word with the oldest prediction.
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string field, input logic want, input logic got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s mismatch, expected %b, got %b", $realtime, field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t v;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: response word with no request behind it", $realtime);
          end
        end else begin
          v = verdicts_due.pop_front();
          if (rsp_bus.matched !== v.matched) begin
            note_mismatch("matched", v.matched, rsp_bus.matched);
          end
          if (rsp_bus.pattern_overflow !== v.pat_ovf) begin
            note_mismatch("pattern_overflow", v.pat_ovf, rsp_bus.pattern_overflow);
          end
          if (rsp_bus.text_overflow !== v.txt_ovf) begin
            note_mismatch("text_overflow", v.txt_ovf, rsp_bus.text_overflow);
          end
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog ends a run that stops moving words on both channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("[wildcard_pattern_matcher_core] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void push_word(input wpm_pkg::req_e kind, input logic [7:0] code);
    req_word_t w;
    w.kind = kind;
    w.code = code;
    send_queue.push_back(w);
    words_queued++;
  endfunction

  // Pattern bytes lean toward the wildcards and a few letters and digits, so that
  // texts built from them hit all the match rules.
  function automatic logic [7:0] pick_pattern_char();
    case ($urandom_range(9))
      0, 1:    return wpm_pkg::CHAR_STAR;
      2:       return wpm_pkg::CHAR_QUESTION;
      3:       return wpm_pkg::CHAR_HASH;
      4:       return wpm_pkg::CHAR_AT;
      5:       return wpm_pkg::CHAR_PERCENT;
      6:       return 8'(8'h61 + $urandom_range(2));
      7:       return 8'(8'h41 + $urandom_range(2));
      8:       return 8'(8'h30 + $urandom_range(1));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // A text byte that the pattern byte accepts; each wildcard class sometimes gets
  // its own symbol, which it must also accept.
  function automatic logic [7:0] fit_text_char(input logic [7:0] p);
    logic [7:0] letter;
    letter = 8'(8'h61 + $urandom_range(25)) & ($urandom_range(1) ? 8'hFF : 8'hDF);
    case (p)
      wpm_pkg::CHAR_QUESTION: return 8'($urandom_range(255));
      wpm_pkg::CHAR_HASH: begin
        return $urandom_range(3) == 0 ? wpm_pkg::CHAR_HASH
                                      : 8'(8'h30 + $urandom_range(9));
      end
      wpm_pkg::CHAR_AT: begin
        return $urandom_range(3) == 0 ? wpm_pkg::CHAR_AT : letter;
      end
      wpm_pkg::CHAR_PERCENT: begin
        case ($urandom_range(3))
          0:       return wpm_pkg::CHAR_PERCENT;
          1:       return 8'(8'h30 + $urandom_range(9));
          default: return letter;
        endcase
      end
      default: begin
        // Flip the case of letters at random.
        if (((p | 8'h20) >= "a") && ((p | 8'h20) <= "z") && $urandom_range(1)) begin
          return p ^ 8'h20;
        end
        return p;
      end
    endcase
  endfunction

  // One session: a new pattern and a few texts, most of them matching, some
  // broken by a changed, dropped or extra byte.
  function automatic void add_session(input bit long_pat, input bit long_txt);
    logic [7:0]  pat[$];
    logic [7:0]  txt[$];
    int unsigned n;
    int unsigned span;
    push_word(wpm_pkg::REQ_CLEAR, 8'($urandom_range(255)));
    n = long_pat ? $urandom_range(PATTERN_MAX + 2, PATTERN_MAX - 4) : $urandom_range(7);
    for (int i = 0; i < n; i++) begin
      pat.push_back(pick_pattern_char());
      push_word(wpm_pkg::REQ_APPEND, pat[i]);
    end
    repeat (long_pat ? 1 : $urandom_range(4, 1)) begin
      if ($urandom_range(3) != 0) begin
        push_word(wpm_pkg::REQ_RESTART, 8'($urandom_range(255)));
      end
      txt.delete();
      for (int i = 0; i < n && i < PATTERN_MAX; i++) begin
        if (pat[i] == wpm_pkg::CHAR_STAR) begin
          repeat ($urandom_range(3)) txt.push_back(8'($urandom_range(255)));
        end else begin
          txt.push_back(fit_text_char(pat[i]));
        end
      end
      case ($urandom_range(9))
        0, 1: if (txt.size() != 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        2:    if (txt.size() != 0) void'(txt.pop_back());
        3:    txt.push_back(fit_text_char(wpm_pkg::CHAR_PERCENT));
        default: ;
      endcase
      // A long text runs the byte count to just below, at or past its limit.
      if (long_txt) begin
        span = $urandom_range(TEXT_MAX + 3, TEXT_MAX - 2);
        while (txt.size() < span) txt.push_back(8'($urandom_range(255)));
        long_txt = 1'b0;
      end
      foreach (txt[i]) push_word(wpm_pkg::REQ_TEXT, txt[i]);
    end
  endfunction

  // Fills the queue with sessions and some noise words of any kind.
  function automatic void add_random_words(input int unsigned count, input bit first);
    int unsigned target;
    int unsigned sessions;
    target   = words_queued + count;
    sessions = 0;
    while (words_queued < target) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(6, 1)) begin
          push_word(wpm_pkg::req_e'($urandom_range(3)), 8'($urandom_range(255)));
        end
      end else begin
        add_session((first && sessions == 0) || $urandom_range(29) == 0,
                    (first && sessions == 1) || $urandom_range(24) == 0);
        sessions++;
      end
    end
  endfunction

  // The sender holds back until every word has gone out and every response is in.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (send_queue.size() != 0 || req_bus.valid || verdicts_due.size() != 0);
  endtask

  initial begin
    req_bus.valid     = 1'b0;
    req_bus.req_type  = wpm_pkg::REQ_CLEAR;
    req_bus.char_code = 8'h00;
    rsp_bus.ready     = 1'b0;
    words_queued      = 0;
    fail_count        = 0;
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    pat_len           = 0;
    pat_ovf           = 1'b0;
    rewind_text();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty pattern: only the empty text matches.
    push_word(wpm_pkg::REQ_RESTART, 8'h00);
    push_word(wpm_pkg::REQ_TEXT, "x");
    // A pattern with every kind of byte, including byte zero and 0xFF, then a
    // text that matches it; '#' and '@' each meet their own symbol.
    push_word(wpm_pkg::REQ_CLEAR, 8'hFF);
    push_word(wpm_pkg::REQ_APPEND, wpm_pkg::CHAR_STAR);
    push_word(wpm_pkg::REQ_APPEND, "A");
    push_word(wpm_pkg::REQ_APPEND, wpm_pkg::CHAR_QUESTION);
    push_word(wpm_pkg::REQ_APPEND, wpm_pkg::CHAR_HASH);
    push_word(wpm_pkg::REQ_APPEND, wpm_pkg::CHAR_AT);
    push_word(wpm_pkg::REQ_APPEND, wpm_pkg::CHAR_PERCENT);
    push_word(wpm_pkg::REQ_APPEND, 8'h00);
    push_word(wpm_pkg::REQ_APPEND, 8'hFF);
    push_word(wpm_pkg::REQ_TEXT, "q");
    push_word(wpm_pkg::REQ_TEXT, "a");
    push_word(wpm_pkg::REQ_TEXT, 8'hC3);
    push_word(wpm_pkg::REQ_TEXT, wpm_pkg::CHAR_HASH);
    push_word(wpm_pkg::REQ_TEXT, wpm_pkg::CHAR_AT);
    push_word(wpm_pkg::REQ_TEXT, "9");
    push_word(wpm_pkg::REQ_TEXT, 8'h00);
    push_word(wpm_pkg::REQ_TEXT, 8'hFF);

    // First phase runs with no idling and forces one long pattern and one long
    // text, each near or past its limit.
    add_random_words(225, 1'b1);
    wait_for_drain();

    send_idle_pct  = 82;
    recv_stall_pct = 0;
    add_random_words(225, 1'b0);
    wait_for_drain();

    send_idle_pct  = 0;
    recv_stall_pct = 82;
    add_random_words(225, 1'b0);
    wait_for_drain();

    send_idle_pct  = 23;
    recv_stall_pct = 23;
    add_random_words(225, 1'b0);
    wait_for_drain();

    repeat (4) @(negedge clk_i);
    if (fail_count == 0 && verdicts_due.size() == 0) begin
      $display("[wildcard_pattern_matcher_core] OK");
    end else begin
      $display("[wildcard_pattern_matcher_core] ERROR");
    end
    $finish;
  end

endmodule
